// ===== src/hcio_pkg.sv =====
package hcio_pkg;

    // Event codes carried in the cmd field
    localparam logic [2:0] CMD_TICK_200K  = 3'd0;
    localparam logic [2:0] CMD_TICK_100   = 3'd1;
    localparam logic [2:0] CMD_WRITE_F0   = 3'd2;
    localparam logic [2:0] CMD_WRITE_KEYL = 3'd3;
    localparam logic [2:0] CMD_READ_F2    = 3'd4;
    localparam logic [2:0] CMD_READ_DC    = 3'd5;
    localparam logic [2:0] CMD_READ_KEYS  = 3'd6;

    // Configuration register indexes
    localparam logic [1:0] CFG_SOUND_ENABLE  = 2'd0;
    localparam logic [1:0] CFG_SLOW_SWITCH   = 2'd1;
    localparam logic [1:0] CFG_VARIANT_FIXED = 2'd2;
    localparam logic [1:0] CFG_SLOWDOWN      = 2'd3;

    // Cassette periods shorter than this many 200 kHz ticks read as short
    localparam logic [7:0] SHORT_PERIOD   = 8'd64;

    localparam logic [7:0] F0_RESET       = 8'hff;
    localparam logic [7:0] F0_FIXED_BITS  = 8'h14;
    localparam logic [7:0] F2_FIXED_BITS  = 8'h08;
    localparam logic [6:0] DC_FIXED_BITS  = 7'h7f;
    localparam logic [3:0] HALT_PHASE_FAST = 4'd8;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [7:0]  wdata;
        logic        cass_level;
        logic [63:0] key_matrix;
        logic [3:0]  dip_switches;
        logic        printer_busy;
    } io_in_t;

    typedef struct packed {
        logic [7:0] rdata;
        logic       speaker_level;
        logic       cass_out;
        logic       motor_on;
        logic       cass_sound_on;
        logic       cpu_halt;
    } io_out_t;

endpackage

// ===== src/home_computer_io_ports.sv =====
// I/O block of a small home computer. Each input transaction carries one bus
// or timer event (cmd) and yields exactly one output transaction holding the
// read byte and the levels of speaker, cassette out, motor, cassette sound and
// CPU halt as they stand after the event. Events: 200 kHz cassette tick (also
// returns the keyboard byte), 100 Hz half-speed tick, port F0 write, key latch
// write, port F2 / DC status reads and keyboard read. The block is a two-stage
// pipe: an input register, then one pass of short logic that updates the
// state and fills the result register. It takes one transaction per clock
// while the result register is free or being emptied; an accepted one passes
// the input register and then the result register before its result is
// offered. While a result waits for out_ready, the input stage takes new input
// only while empty. Configuration is written through cfg_we/cfg_index/
// cfg_data and must only change while no transaction is in flight.
module home_computer_io_ports (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  hcio_pkg::io_in_t     in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output hcio_pkg::io_out_t    out_data,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic                 cfg_data
);
    import hcio_pkg::*;

    // Configuration
    logic sound_enable_reg, slow_switch_reg, variant_fixed_reg, slowdown_present_reg;

    // Pipe stages
    logic    in_valid_reg;
    io_in_t  in_data_reg;
    logic    out_valid_reg;
    io_out_t out_data_reg;
    io_out_t out_data_next;
    logic    advance;

    // Block state
    logic [7:0] key_latch_reg,      key_latch_next;
    logic [7:0] port_f0_reg,        port_f0_next;
    logic [7:0] prev_f0_write_reg,  prev_f0_write_next;
    logic       prev_wave_reg,      prev_wave_next;
    logic [7:0] period_count_reg,   period_count_next;
    logic [2:0] cass_status_reg,    cass_status_next;
    logic       flipflop_reg,       flipflop_next;
    logic [3:0] halt_phase_reg,     halt_phase_next;
    logic       halt_line_reg,      halt_line_next;
    logic       motor_reg,          motor_next;
    logic       sound_reg,          sound_next;

    logic [7:0] keys;
    logic [7:0] period_inc;
    logic [3:0] phase_inc;
    logic       slow_mode;
    logic [7:0] rdata;

    // The input stage moves on whenever the result register is free or
    // being emptied in this cycle.
    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Keyboard scan: rows whose latch bit is low pull down their column bits.
    always_comb
    begin
        keys = 8'hff;
        for (int r = 0; r < 8; r++)
        begin
            if (!key_latch_reg[r])
            begin
                keys = keys & in_data_reg.key_matrix[8*r +: 8];
            end
        end
    end

    assign period_inc = period_count_reg + 8'd1;
    assign phase_inc  = halt_phase_reg + 4'd1;
    assign slow_mode  = slow_switch_reg && port_f0_reg[2];

    always_comb
    begin
        key_latch_next     = key_latch_reg;
        port_f0_next       = port_f0_reg;
        prev_f0_write_next = prev_f0_write_reg;
        prev_wave_next     = prev_wave_reg;
        period_count_next  = period_count_reg;
        cass_status_next   = cass_status_reg;
        flipflop_next      = flipflop_reg;
        halt_phase_next    = halt_phase_reg;
        halt_line_next     = halt_line_reg;
        motor_next         = motor_reg;
        sound_next         = sound_reg;
        rdata              = 8'h00;

        case (in_data_reg.cmd)
            CMD_TICK_200K:
            begin
                period_count_next = period_inc;
                if (in_data_reg.cass_level != prev_wave_reg)
                begin
                    // only a rising edge toggles the flip-flop
                    flipflop_next     = flipflop_reg ^ in_data_reg.cass_level;
                    prev_wave_next    = in_data_reg.cass_level;
                    cass_status_next  = {in_data_reg.cass_level, flipflop_next,
                                         (period_inc < SHORT_PERIOD)};
                    period_count_next = 8'd0;
                end
                rdata = keys;
            end
            CMD_TICK_100:
            begin
                if (slowdown_present_reg)
                begin
                    if (slow_mode)
                    begin
                        if (halt_phase_reg == 4'd0)
                        begin
                            halt_line_next = 1'b1;
                        end
                        halt_phase_next = phase_inc;
                        if (phase_inc > 4'd1)
                        begin
                            halt_line_next  = 1'b0;
                            halt_phase_next = 4'd0;
                        end
                    end
                    else if (halt_phase_reg < HALT_PHASE_FAST)
                    begin
                        halt_line_next  = 1'b0;
                        halt_phase_next = HALT_PHASE_FAST;
                    end
                end
            end
            CMD_WRITE_F0:
            begin
                if (in_data_reg.wdata[1] != prev_f0_write_reg[1])
                begin
                    motor_next = !in_data_reg.wdata[1];
                    sound_next = sound_enable_reg;
                end
                port_f0_next       = in_data_reg.wdata
                                     | (variant_fixed_reg ? F0_FIXED_BITS : 8'h00);
                prev_f0_write_next = in_data_reg.wdata;
            end
            CMD_WRITE_KEYL:
            begin
                key_latch_next = in_data_reg.wdata;
            end
            CMD_READ_F2:
            begin
                rdata = {in_data_reg.dip_switches, F2_FIXED_BITS[3], cass_status_reg};
            end
            CMD_READ_DC:
            begin
                rdata = {in_data_reg.printer_busy, DC_FIXED_BITS};
            end
            CMD_READ_KEYS:
            begin
                rdata = keys;
            end
            default:
            begin
                rdata = 8'h00;
            end
        endcase

        out_data_next.rdata         = rdata;
        out_data_next.speaker_level = !port_f0_next[3];
        out_data_next.cass_out      = port_f0_next[0];
        out_data_next.motor_on      = motor_next;
        out_data_next.cass_sound_on = sound_next;
        out_data_next.cpu_halt      = halt_line_next;
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sound_enable_reg     <= 1'b0;
            slow_switch_reg      <= 1'b1;
            variant_fixed_reg    <= 1'b0;
            slowdown_present_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SOUND_ENABLE:  sound_enable_reg     <= cfg_data;
                CFG_SLOW_SWITCH:   slow_switch_reg      <= cfg_data;
                CFG_VARIANT_FIXED: variant_fixed_reg    <= cfg_data;
                CFG_SLOWDOWN:      slowdown_present_reg <= cfg_data;
                default:           sound_enable_reg     <= sound_enable_reg;
            endcase
        end
    end

    // Pipe control and block state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            key_latch_reg     <= 8'h00;
            port_f0_reg       <= F0_RESET;
            prev_f0_write_reg <= 8'h00;
            prev_wave_reg     <= 1'b0;
            period_count_reg  <= 8'h00;
            cass_status_reg   <= 3'd0;
            flipflop_reg      <= 1'b0;
            halt_phase_reg    <= 4'd0;
            halt_line_reg     <= 1'b0;
            motor_reg         <= 1'b0;
            sound_reg         <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                key_latch_reg     <= key_latch_next;
                port_f0_reg       <= port_f0_next;
                prev_f0_write_reg <= prev_f0_write_next;
                prev_wave_reg     <= prev_wave_next;
                period_count_reg  <= period_count_next;
                cass_status_reg   <= cass_status_next;
                flipflop_reg      <= flipflop_next;
                halt_phase_reg    <= halt_phase_next;
                halt_line_reg     <= halt_line_next;
                motor_reg         <= motor_next;
                sound_reg         <= sound_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_data_reg <= in_data;
        end
        if (advance)
        begin
            out_data_reg <= out_data_next;
        end
    end

    // Halt is only ever held in the phase straight after it was raised
    a_halt_phase: assert property (@(posedge clk) disable iff (!rst_n)
        halt_line_reg |-> halt_phase_reg == 4'd1)
        else $error("halt line high outside phase one");

    // Phase only visits rest, halted and fast
    a_phase_set: assert property (@(posedge clk) disable iff (!rst_n)
        halt_phase_reg == 4'd0 || halt_phase_reg == 4'd1 ||
        halt_phase_reg == HALT_PHASE_FAST)
        else $error("half speed phase out of its set");

    // A comparator change restarts the period count
    a_period_clear: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_data_reg.cmd == CMD_TICK_200K &&
        in_data_reg.cass_level != prev_wave_reg |=> period_count_reg == 8'd0)
        else $error("period count not cleared on cassette edge");

    // An accepted transaction always lands in the input stage
    a_in_capture: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> in_valid_reg)
        else $error("accepted transaction lost");

    // Result follows the stored F0 value
    a_speaker: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_data_reg.speaker_level == !port_f0_reg[3])
        else $error("speaker level out of step with port F0");

endmodule
